>>> rtl/core/flcb_pkg.sv
// Shared types and constants of the face list to CSR builder.
package flcb_pkg;

  localparam int unsigned MAX_CELLS_DEF = 1024;
  localparam int unsigned MAX_FACES_DEF = 2048;
  localparam int unsigned NUM_CELLS_RST = 1024;

  localparam int unsigned CELL_W  = 10;
  localparam int unsigned INDEX_W = 12;
  localparam int unsigned VALUE_W = 13;
  localparam int unsigned NCFG_W  = 11;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ROW   = 2'd1,
    REQ_COL   = 2'd2,
    REQ_LOWER = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [CELL_W-1:0]  owner_cell;
    logic [CELL_W-1:0]  neighbour_cell;
    logic               last_face;
    logic [INDEX_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [NCFG_W-1:0] num_cells;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bld_stat_t;

endpackage

>>> rtl/core/flcb_chan_if.sv
// Valid/ready channel carrying one payload word.
interface flcb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/flcb_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module flcb_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 16,
  parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/core/flcb_builder.sv
// Build sequencer: cursor clear, row counting, prefix sum and two scatter passes.
module flcb_builder import flcb_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned MAX_FACES = MAX_FACES_DEF,
  localparam int unsigned CW   = $clog2(MAX_CELLS + 1),
  localparam int unsigned RAW  = $clog2(MAX_CELLS),
  localparam int unsigned RPAW = $clog2(MAX_CELLS + 1),
  localparam int unsigned FTW  = $clog2(MAX_FACES + 1),
  localparam int unsigned FAW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
  localparam int unsigned ED   = 2 * MAX_FACES,
  localparam int unsigned EAW  = $clog2(ED),
  localparam int unsigned EW   = $clog2(ED + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CW-1:0]     cells_i,
  input  logic [FTW-1:0]    faces_i,
  output logic              face_re_o,
  output logic [FAW-1:0]    face_raddr_o,
  input  logic [CELL_W-1:0] face_own_i,
  input  logic [CELL_W-1:0] face_nei_i,
  output logic              rp_we_o,
  output logic [RPAW-1:0]   rp_waddr_o,
  output logic [EW-1:0]     rp_wdata_o,
  output logic              col_we_o,
  output logic [EAW-1:0]    col_waddr_o,
  output logic [CELL_W-1:0] col_wdata_o,
  output logic              lo_we_o,
  output logic [FAW-1:0]    lo_waddr_o,
  output logic [EW-1:0]     lo_wdata_o,
  output logic [EW-1:0]     entries_o,
  output bld_stat_t         stat_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_CNT_FACE, S_CNT_O, S_CNT_OW, S_CNT_B, S_CNT_BW,
    S_PFX_RD, S_PFX_WR, S_SC_FACE, S_SC_CUR, S_SC_WR, S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      r_q;
  logic [FTW-1:0]     f_q;
  logic [EW-1:0]      sum_q;
  logic [CELL_W-1:0]  own_q, nei_q;
  logic               pass_q;

  logic               cur_we, cur_re;
  logic [RAW-1:0]     cur_waddr, cur_raddr;
  logic [EW-1:0]      cur_wdata, cur_rdata;
  logic               last_row, last_face;
  logic [CELL_W-1:0]  sc_row;

  flcb_ram #(.W(EW), .D(MAX_CELLS), .AW(RAW)) u_cursor (
    .clk_i, .we_i(cur_we), .waddr_i(cur_waddr), .wdata_i(cur_wdata),
    .re_i(cur_re), .raddr_i(cur_raddr), .rdata_o(cur_rdata)
  );

  assign last_row  = (r_q == cells_i - 1'b1);
  assign last_face = (f_q == faces_i - 1'b1);
  assign sc_row    = pass_q ? own_q : nei_q;

  always_comb begin
    cur_we = 1'b0; cur_waddr = '0; cur_wdata = '0;
    cur_re = 1'b0; cur_raddr = '0;
    face_re_o = 1'b0; face_raddr_o = FAW'(f_q);
    rp_we_o = 1'b0; rp_waddr_o = '0; rp_wdata_o = '0;
    col_we_o = 1'b0; col_waddr_o = EAW'(cur_rdata);
    col_wdata_o = pass_q ? nei_q : own_q;
    lo_we_o = 1'b0; lo_waddr_o = FAW'(f_q); lo_wdata_o = cur_rdata;
    case (state_q)
      S_CLR: begin
        cur_we = 1'b1; cur_waddr = RAW'(r_q);
        rp_we_o = (r_q == '0);
      end
      S_CNT_FACE, S_SC_FACE: begin
        face_re_o = 1'b1;
      end
      S_CNT_O: begin
        cur_re = 1'b1; cur_raddr = RAW'(face_own_i);
      end
      S_CNT_OW: begin
        cur_we = 1'b1; cur_waddr = RAW'(own_q); cur_wdata = cur_rdata + 1'b1;
      end
      S_CNT_B: begin
        cur_re = 1'b1; cur_raddr = RAW'(nei_q);
      end
      S_CNT_BW: begin
        cur_we = 1'b1; cur_waddr = RAW'(nei_q); cur_wdata = cur_rdata + 1'b1;
      end
      S_PFX_RD: begin
        cur_re = 1'b1; cur_raddr = RAW'(r_q);
      end
      S_PFX_WR: begin
        cur_we = 1'b1; cur_waddr = RAW'(r_q); cur_wdata = sum_q;
        rp_we_o = 1'b1; rp_waddr_o = RPAW'(r_q) + 1'b1;
        rp_wdata_o = sum_q + cur_rdata;
      end
      S_SC_CUR: begin
        cur_re = 1'b1;
        cur_raddr = pass_q ? RAW'(face_own_i) : RAW'(face_nei_i);
      end
      S_SC_WR: begin
        cur_we = 1'b1; cur_waddr = RAW'(sc_row); cur_wdata = cur_rdata + 1'b1;
        col_we_o = (cur_rdata < EW'(ED));
        lo_we_o = !pass_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      r_q <= '0; f_q <= '0; sum_q <= '0; pass_q <= 1'b0;
      own_q <= '0; nei_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_CLR; r_q <= '0;
          end
        end
        S_CLR: begin
          if (last_row) begin
            r_q <= '0; f_q <= '0; sum_q <= '0;
            state_q <= (faces_i == '0) ? S_PFX_RD : S_CNT_FACE;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        S_CNT_FACE: state_q <= S_CNT_O;
        S_CNT_O: begin
          own_q <= face_own_i; nei_q <= face_nei_i; state_q <= S_CNT_OW;
        end
        S_CNT_OW: state_q <= S_CNT_B;
        S_CNT_B:  state_q <= S_CNT_BW;
        S_CNT_BW: begin
          if (last_face) begin
            state_q <= S_PFX_RD;
          end else begin
            f_q <= f_q + 1'b1; state_q <= S_CNT_FACE;
          end
        end
        S_PFX_RD: state_q <= S_PFX_WR;
        S_PFX_WR: begin
          sum_q <= sum_q + cur_rdata;
          if (last_row) begin
            f_q <= '0; pass_q <= 1'b0;
            state_q <= (faces_i == '0) ? S_DONE : S_SC_FACE;
          end else begin
            r_q <= r_q + 1'b1; state_q <= S_PFX_RD;
          end
        end
        S_SC_FACE: state_q <= S_SC_CUR;
        S_SC_CUR: begin
          own_q <= face_own_i; nei_q <= face_nei_i; state_q <= S_SC_WR;
        end
        S_SC_WR: begin
          if (last_face) begin
            f_q <= '0;
            if (pass_q) begin
              state_q <= S_DONE;
            end else begin
              pass_q <= 1'b1; state_q <= S_SC_FACE;
            end
          end else begin
            f_q <= f_q + 1'b1; state_q <= S_SC_FACE;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign entries_o   = sum_q;
  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
endmodule

>>> rtl/core/face_list_to_csr_builder.sv
// Top level of the face list to CSR pattern builder.
// Faces come in as owner/neighbour words and are appended to a face list RAM;
// a face with a cell not below num_cells, or beyond MAX_FACES, is dropped and
// sets a sticky flag that later in-range results report as status 2. A load word
// accepted gives no result unless it is the last face. A read word (row
// pointer, column index, face lower position) is answered through the RAM
// read register and then the output register, and the next word is taken
// once the result has been taken. The last face starts the build, which
// runs on the single cursor RAM: it clears the cursors, counts the two cells
// of each face, forms the prefix sum over the rows and then scatters
// the faces in two scatter passes. Its result carries the face count. Writing
// num_cells starts a new mesh; row pointers read as zero until the first
// build, so no clearing pass follows reset.
module face_list_to_csr_builder import flcb_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned MAX_FACES = MAX_FACES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  flcb_chan_if.sink           item_i,
  flcb_chan_if.source         result_o,
  flcb_chan_if.sink           cfg_i
);
  localparam int unsigned CW   = $clog2(MAX_CELLS + 1);
  localparam int unsigned RPAW = $clog2(MAX_CELLS + 1);
  localparam int unsigned FTW  = $clog2(MAX_FACES + 1);
  localparam int unsigned FAW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int unsigned ED   = 2 * MAX_FACES;
  localparam int unsigned EAW  = $clog2(ED);
  localparam int unsigned EW   = $clog2(ED + 1);
  localparam int unsigned CELLS_RST =
    (NUM_CELLS_RST > MAX_CELLS) ? MAX_CELLS : NUM_CELLS_RST;

  req_t          req;
  logic          item_acc, cfg_acc, is_load, face_ok;
  logic [CW-1:0] cells_q, cells_cfg;
  logic [31:0]   cfg_val;
  logic [FTW-1:0] total_q, built_q;
  logic [EW-1:0] entries_q;
  logic          drop_q, drop_now, rp_valid_q, start_q;
  logic          pend_q, pend_range_q;
  req_type_e     pend_type_q;
  logic          out_valid_q;
  rsp_t          out_q;
  logic          in_range;
  logic [VALUE_W-1:0] read_val;

  logic              face_re;
  logic [FAW-1:0]    face_raddr;
  logic [2*CELL_W-1:0] face_rdata;
  logic              rp_we, col_we, lo_we;
  logic [RPAW-1:0]   rp_waddr;
  logic [EW-1:0]     rp_wdata, lo_wdata, rp_rdata, lo_rdata, bld_entries;
  logic [EAW-1:0]    col_waddr;
  logic [CELL_W-1:0] col_wdata, col_rdata;
  logic [FAW-1:0]    lo_waddr;
  bld_stat_t         bld_stat;

  assign req      = item_i.data;
  assign is_load  = (req.req_type == REQ_LOAD);
  assign item_i.ready = !bld_stat.busy && !start_q && !pend_q && !out_valid_q;
  assign item_acc = item_i.valid && item_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_acc  = cfg_i.valid;

  // Clamp the cell count to 1..MAX_CELLS.
  assign cfg_val = 32'(cfg_i.data.num_cells);
  assign cells_cfg = (cfg_val == '0) ? CW'(1) :
                     (cfg_val > MAX_CELLS) ? CW'(MAX_CELLS) : CW'(cfg_val);

  assign face_ok = (total_q < FTW'(MAX_FACES)) &&
                   (req.owner_cell < cells_q) && (req.neighbour_cell < cells_q);
  assign drop_now = drop_q || (item_acc && is_load && !face_ok);

  always_comb begin
    case (req.req_type)
      REQ_ROW:   in_range = (req.read_index <= cells_q);
      REQ_COL:   in_range = (req.read_index < entries_q);
      REQ_LOWER: in_range = (req.read_index < built_q);
      default:   in_range = 1'b1;
    endcase
  end

  flcb_ram #(.W(2*CELL_W), .D(MAX_FACES), .AW(FAW)) u_faces (
    .clk_i, .we_i(item_acc && is_load && face_ok), .waddr_i(FAW'(total_q)),
    .wdata_i({req.owner_cell, req.neighbour_cell}),
    .re_i(face_re), .raddr_i(face_raddr), .rdata_o(face_rdata)
  );

  flcb_ram #(.W(EW), .D(MAX_CELLS + 1), .AW(RPAW)) u_rowptr (
    .clk_i, .we_i(rp_we), .waddr_i(rp_waddr), .wdata_i(rp_wdata),
    .re_i(item_acc), .raddr_i(RPAW'(req.read_index)), .rdata_o(rp_rdata)
  );

  flcb_ram #(.W(CELL_W), .D(ED), .AW(EAW)) u_colidx (
    .clk_i, .we_i(col_we), .waddr_i(col_waddr), .wdata_i(col_wdata),
    .re_i(item_acc), .raddr_i(EAW'(req.read_index)), .rdata_o(col_rdata)
  );

  flcb_ram #(.W(EW), .D(MAX_FACES), .AW(FAW)) u_lower (
    .clk_i, .we_i(lo_we), .waddr_i(lo_waddr), .wdata_i(lo_wdata),
    .re_i(item_acc), .raddr_i(FAW'(req.read_index)), .rdata_o(lo_rdata)
  );

  flcb_builder #(.MAX_CELLS(MAX_CELLS), .MAX_FACES(MAX_FACES)) u_builder (
    .clk_i, .rst_ni, .start_i(start_q), .cells_i(cells_q), .faces_i(total_q),
    .face_re_o(face_re), .face_raddr_o(face_raddr),
    .face_own_i(face_rdata[2*CELL_W-1:CELL_W]), .face_nei_i(face_rdata[CELL_W-1:0]),
    .rp_we_o(rp_we), .rp_waddr_o(rp_waddr), .rp_wdata_o(rp_wdata),
    .col_we_o(col_we), .col_waddr_o(col_waddr), .col_wdata_o(col_wdata),
    .lo_we_o(lo_we), .lo_waddr_o(lo_waddr), .lo_wdata_o(lo_wdata),
    .entries_o(bld_entries), .stat_o(bld_stat)
  );

  // Select the read word that the RAMs return in the cycle after accept.
  always_comb begin
    case (pend_type_q)
      REQ_ROW:   read_val = rp_valid_q ? VALUE_W'(rp_rdata) : '0;
      REQ_COL:   read_val = VALUE_W'(col_rdata);
      REQ_LOWER: read_val = VALUE_W'(lo_rdata);
      default:   read_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_q <= CW'(CELLS_RST);
      total_q <= '0; built_q <= '0; entries_q <= '0;
      drop_q <= 1'b0; rp_valid_q <= 1'b0; start_q <= 1'b0;
      pend_q <= 1'b0; pend_range_q <= 1'b0; pend_type_q <= REQ_LOAD;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      start_q <= 1'b0;
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        // New mesh: drop the face list and the last build.
        cells_q <= cells_cfg;
        total_q <= '0; built_q <= '0; entries_q <= '0;
        drop_q <= 1'b0; rp_valid_q <= 1'b0;
      end else if (item_acc) begin
        drop_q <= drop_now;
        if (is_load) begin
          if (face_ok) begin
            total_q <= total_q + 1'b1;
          end
          start_q <= req.last_face;
        end else begin
          pend_q <= 1'b1;
          pend_range_q <= in_range;
          pend_type_q <= req_type_e'(req.req_type);
        end
      end
      if (pend_q) begin
        pend_q <= 1'b0;
        out_valid_q <= 1'b1;
        out_q.read_value <= pend_range_q ? read_val : '0;
        out_q.status <= !pend_range_q ? ST_RANGE : (drop_q ? ST_DROPPED : ST_OK);
      end
      if (bld_stat.done) begin
        built_q <= total_q;
        entries_q <= bld_entries;
        rp_valid_q <= 1'b1;
        out_valid_q <= 1'b1;
        out_q.read_value <= VALUE_W'(total_q);
        out_q.status <= drop_q ? ST_DROPPED : ST_OK;
      end
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // Every face held adds one entry to its owner row and one to its neighbour row, so a finished build has 2F entries.
  a_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_valid_q |-> (32'(entries_q) == 2 * 32'(built_q)))
    else $error("entry count does not match faces built");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_stat.busy |-> !item_i.ready)
    else $error("input taken during build");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_o.valid) |-> $past(pend_q || bld_stat.done))
    else $error("result without a read or a build");

  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> bld_stat.busy)
    else $error("build did not start");
endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the face list to CSR builder: predicted CSR reads.
module tb_top;
  import flcb_pkg::*;

  localparam int unsigned N_MAX      = MAX_CELLS_DEF;
  localparam int unsigned F_MAX      = MAX_FACES_DEF;
  // Quiet cycles before a num_cells write or the end of a drain.
  localparam int unsigned SETTLE     = 8;
  // Watchdog limit; leave a wide margin over the longest build.
  localparam int unsigned STALL_LIMIT = 200000;
  localparam int unsigned TARGET_ITEMS = 950;

  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_CFG,
    ACT_DRAIN
  } act_e;

  typedef struct {
    act_e          kind;
    req_t          word;
    logic [10:0]   cells;
  } act_t;

  logic clk_i;
  logic rst_ni;

  flcb_chan_if #(.payload_t(req_t)) item_if ();
  flcb_chan_if #(.payload_t(rsp_t)) result_if ();
  flcb_chan_if #(.payload_t(cfg_t)) cfg_if ();

  face_list_to_csr_builder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  // Stimulus waiting to be driven, and results waiting to be seen.
  act_t pending_acts[$];
  rsp_t expected_rsps[$];
  int   mismatch_count;
  int   stall_cycles;

  // Shadow of the builder: face list, CSR pattern and per-face lower slot.
  logic [CELL_W-1:0]  mesh_owner [F_MAX];
  logic [CELL_W-1:0]  mesh_nbr [F_MAX];
  logic [VALUE_W-1:0] mesh_row_ptr [N_MAX+1];
  logic [CELL_W-1:0]  mesh_col [2*F_MAX];
  logic [INDEX_W-1:0] mesh_lower [F_MAX];
  int unsigned        mesh_faces;
  int unsigned        mesh_built;
  bit                 mesh_dropped;
  logic [10:0]        mesh_cfg_cells;

  function automatic int unsigned active_cells();
    int unsigned n;
    n = 32'(mesh_cfg_cells);
    if (n < 1) n = 1;
    if (n > N_MAX) n = N_MAX;
    return n;
  endfunction

  function automatic void start_mesh(logic [10:0] cells);
    mesh_cfg_cells = cells;
    mesh_faces     = 0;
    mesh_built     = 0;
    mesh_dropped   = 0;
    for (int r = 0; r <= N_MAX; r++) mesh_row_ptr[r] = '0;
  endfunction

  // Count, prefix-sum, then scatter lower entries before upper entries.
  function automatic void build_pattern();
    int unsigned n;
    int unsigned cursor [N_MAX];
    int unsigned total;
    int unsigned slot;
    n = active_cells();
    for (int r = 0; r < N_MAX; r++) cursor[r] = 0;
    for (int f = 0; f < mesh_faces; f++) begin
      cursor[mesh_owner[f]]++;
      cursor[mesh_nbr[f]]++;
    end
    total = 0;
    mesh_row_ptr[0] = '0;
    for (int r = 0; r < n; r++) begin
      slot = cursor[r];
      cursor[r] = total;
      total += slot;
      mesh_row_ptr[r+1] = VALUE_W'(total);
    end
    for (int f = 0; f < mesh_faces; f++) begin
      slot = cursor[mesh_nbr[f]];
      mesh_lower[f] = INDEX_W'(slot);
      mesh_col[slot] = mesh_owner[f];
      cursor[mesh_nbr[f]] = slot + 1;
    end
    for (int f = 0; f < mesh_faces; f++) begin
      slot = cursor[mesh_owner[f]];
      mesh_col[slot] = mesh_nbr[f];
      cursor[mesh_owner[f]] = slot + 1;
    end
    mesh_built = mesh_faces;
  endfunction

  // Apply one accepted word; push a result where the word causes one.
  function automatic void predict_word(req_t w);
    int unsigned n;
    rsp_t r;
    bit ok;
    n  = active_cells();
    ok = 1;
    r.read_value = '0;
    case (req_type_e'(w.req_type))
      REQ_LOAD: begin
        if (mesh_faces >= F_MAX || w.owner_cell >= n || w.neighbour_cell >= n) begin
          mesh_dropped = 1;
        end else begin
          mesh_owner[mesh_faces] = w.owner_cell;
          mesh_nbr[mesh_faces]   = w.neighbour_cell;
          mesh_faces++;
        end
        if (!w.last_face) return;
        build_pattern();
        r.read_value = VALUE_W'(mesh_built);
      end
      REQ_ROW: begin
        if (w.read_index <= n) r.read_value = mesh_row_ptr[w.read_index];
        else ok = 0;
      end
      REQ_COL: begin
        if (w.read_index < mesh_row_ptr[n]) r.read_value = VALUE_W'(mesh_col[w.read_index]);
        else ok = 0;
      end
      default: begin
        if (w.read_index < mesh_built) r.read_value = VALUE_W'(mesh_lower[w.read_index]);
        else ok = 0;
      end
    endcase
    if (!ok) begin
      r.read_value = '0;
      r.status     = ST_RANGE;
    end else begin
      r.status = mesh_dropped ? ST_DROPPED : ST_OK;
    end
    expected_rsps.push_back(r);
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // ---------------------------------------------------------------- stimulus
  int unsigned queued_words;
  int unsigned plan_faces;

  function automatic void queue_word(req_type_e kind, int unsigned own, int unsigned nbr,
                                     bit last, int unsigned idx);
    act_t a;
    a.kind                = ACT_WORD;
    a.cells               = '0;
    a.word.req_type       = kind;
    a.word.owner_cell     = CELL_W'(own);
    a.word.neighbour_cell = CELL_W'(nbr);
    a.word.last_face      = last;
    a.word.read_index     = INDEX_W'(idx);
    pending_acts.push_back(a);
    queued_words++;
  endfunction

  function automatic void queue_cfg(int unsigned cells);
    act_t a;
    a.kind  = ACT_CFG;
    a.word  = '0;
    a.cells = 11'(cells);
    pending_acts.push_back(a);
    plan_faces = 0;
  endfunction

  function automatic void queue_drain();
    act_t a;
    a.kind  = ACT_DRAIN;
    a.word  = '0;
    a.cells = '0;
    pending_acts.push_back(a);
  endfunction

  // A read with random junk in the fields that a read ignores.
  function automatic void queue_read(req_type_e kind, int unsigned idx);
    queue_word(kind, $urandom_range(1023), $urandom_range(1023), $urandom_range(1), idx);
  endfunction

  // Reads aimed mostly inside the pattern of the last build, some anywhere.
  function automatic void queue_random_reads(int unsigned n, int unsigned count);
    req_type_e kind;
    int unsigned idx;
    for (int i = 0; i < count; i++) begin
      kind = req_type_e'($urandom_range(3, 1));
      if ($urandom_range(9) == 0) idx = $urandom_range(4095);
      else case (kind)
        REQ_ROW: idx = $urandom_range(n + 1);
        REQ_COL: idx = $urandom_range(2 * plan_faces + 2);
        default: idx = $urandom_range(plan_faces + 1);
      endcase
      queue_read(kind, idx);
    end
  endfunction

  // Loads whose cells mostly fit; the rest may name a cell out of range and be dropped.
  function automatic void queue_faces(int unsigned n, int unsigned count, bit finish);
    int unsigned own;
    int unsigned nbr;
    for (int i = 0; i < count; i++) begin
      own = $urandom_range(n - 1);
      nbr = $urandom_range(n - 1);
      if ($urandom_range(11) == 0) begin
        if ($urandom_range(1)) own = $urandom_range(1023);
        else nbr = $urandom_range(1023);
      end
      queue_word(REQ_LOAD, own, nbr, finish && (i == count - 1), 0);
      plan_faces++;
    end
  endfunction

  initial begin
    int unsigned n;
    int unsigned p;
    queued_words = 0;
    plan_faces   = 0;
    mismatch_count = 0;
    start_mesh(11'(NUM_CELLS_RST));

    // Directed: reads before any build, at the reset size.
    queue_read(REQ_ROW, 0);
    queue_read(REQ_ROW, 1024);
    queue_read(REQ_ROW, 1025);
    queue_read(REQ_COL, 0);
    queue_read(REQ_LOWER, 0);
    // Extreme cells, a plain load, then the last face builds.
    queue_word(REQ_LOAD, 0, 1023, 0, 0);
    queue_word(REQ_LOAD, 1023, 0, 1, 4095);
    queue_read(REQ_ROW, 1);
    queue_read(REQ_ROW, 1024);
    queue_read(REQ_COL, 3);
    queue_read(REQ_COL, 4);
    queue_read(REQ_LOWER, 1);
    queue_read(REQ_LOWER, 2);
    // Rebuild over the appended face.
    queue_word(REQ_LOAD, 5, 5, 1, 0);
    queue_read(REQ_LOWER, 2);
    queue_drain();
    // Single cell; a dropped face, then a dropped last face still builds.
    queue_cfg(1);
    queue_word(REQ_LOAD, 0, 0, 0, 0);
    queue_word(REQ_LOAD, 1, 0, 0, 0);
    queue_word(REQ_LOAD, 0, 1, 1, 0);
    queue_read(REQ_ROW, 1);
    queue_read(REQ_COL, 1);
    queue_read(REQ_LOWER, 0);
    // Zero and oversize counts clamp.
    queue_cfg(0);
    queue_read(REQ_ROW, 1);
    queue_read(REQ_ROW, 2);
    queue_cfg(2047);
    queue_read(REQ_ROW, 1024);

    // Random phases of well-formed meshes with some noise.
    while (queued_words < TARGET_ITEMS) begin
      p = $urandom_range(99);
      if (p < 45) n = $urandom_range(16, 1);
      else if (p < 70) n = $urandom_range(64, 2);
      else if (p < 80) n = $urandom_range(1024, 1);
      else if (p < 90) n = 1024;
      else if (p < 95) n = 2;
      else n = 1;
      if ($urandom_range(19) == 0) queue_cfg($urandom_range(2047));
      else queue_cfg(n);
      for (int b = $urandom_range(3, 1); b > 0; b--) begin
        queue_faces(n, $urandom_range(12, 1), 1);
        queue_random_reads(n, $urandom_range(10, 3));
        if ($urandom_range(7) == 0) queue_drain();
        if ($urandom_range(9) == 0) queue_faces(n, 2, 0);
      end
    end
  end

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- driver
  int unsigned send_gap;
  int unsigned quiet_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    logic next_cfg_valid;
    req_t next_word;
    cfg_t next_cfg;
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.data  <= '0;
      cfg_if.valid  <= 1'b0;
      cfg_if.data   <= '0;
      send_gap      <= 0;
      quiet_cycles  <= 0;
    end else begin
      next_valid     = item_if.valid;
      next_cfg_valid = cfg_if.valid;
      next_word      = item_if.data;
      next_cfg       = cfg_if.data;
      // Hold a word until it is taken.
      if (item_if.valid && item_if.ready) next_valid = 1'b0;
      if (cfg_if.valid && cfg_if.ready) next_cfg_valid = 1'b0;
      if (!next_valid && !next_cfg_valid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_acts.size() > 0) begin
          case (pending_acts[0].kind)
            ACT_WORD: begin
              next_valid = 1'b1;
              next_word  = pending_acts[0].word;
              void'(pending_acts.pop_front());
              send_gap <= pick_gap();
            end
            default: begin
              // Drain every expected result, then let the block settle.
              if (expected_rsps.size() != 0 || item_if.valid || cfg_if.valid) begin
                quiet_cycles <= 0;
              end else if (quiet_cycles < SETTLE) begin
                quiet_cycles <= quiet_cycles + 1;
              end else begin
                quiet_cycles <= 0;
                if (pending_acts[0].kind == ACT_CFG) begin
                  next_cfg_valid     = 1'b1;
                  next_cfg.num_cells = pending_acts[0].cells;
                end
                void'(pending_acts.pop_front());
              end
            end
          endcase
        end
      end
      item_if.valid <= next_valid;
      item_if.data  <= next_word;
      cfg_if.valid  <= next_cfg_valid;
      cfg_if.data   <= next_cfg;
    end
  end

  // Result side back-pressure.
  int unsigned sink_stall;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      sink_stall      <= 0;
    end else if (sink_stall > 0) begin
      result_if.ready <= 1'b0;
      sink_stall      <= sink_stall - 1;
    end else begin
      result_if.ready <= 1'b1;
      if (result_if.valid && result_if.ready) sink_stall <= pick_gap();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) start_mesh(cfg_if.data.num_cells);
      if (item_if.valid && item_if.ready) predict_word(item_if.data);
      if (result_if.valid && result_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $time,
                   result_if.data.read_value, result_if.data.status);
          mismatch_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (result_if.data.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time,
                     want.read_value, result_if.data.read_value);
            mismatch_count++;
          end
          if (result_if.data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result_if.data.status);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (cfg_if.valid && cfg_if.ready)
        || (result_if.valid && result_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_rsps.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- end
  initial begin
    stall_cycles = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    while (pending_acts.size() != 0 || item_if.valid || cfg_if.valid
           || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
